// ===== rtl/rbmf_pkg.sv =====
// ---------------------------------------------------------------------------
// rbmf_pkg
// Shared types and constants of the RGB box mean filter.
// ---------------------------------------------------------------------------
package rbmf_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 1024;
  localparam int MAX_RADIUS_X = 2;
  localparam int MAX_RADIUS_Y = 2;

  localparam int CFG_W    = 11;
  localparam int RAD_W    = 2;
  localparam int ADDR_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int LINES    = 2 * MAX_RADIUS_Y;
  localparam int WIN_ROWS = 2 * MAX_RADIUS_Y + 1;
  localparam int WIN_COLS = 2 * MAX_RADIUS_X + 1;
  localparam int CH_W     = 8;
  localparam int PIX_W    = 3 * CH_W;
  localparam int LINE_W   = LINES * PIX_W;
  localparam int COLSUM_W = $clog2(WIN_ROWS * 255 + 1);
  localparam int SUM_W    = $clog2(WIN_ROWS * WIN_COLS * 255 + 1);
  localparam int RECIP_SH = 24;
  localparam int RECIP_W  = RECIP_SH + 1;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_RADIUS_X     = 2'd2,
    REG_RADIUS_Y     = 2'd3
  } reg_idx_t;

  // one window column, row 0 is the newest pixel
  typedef logic [WIN_ROWS-1:0][PIX_W-1:0] colpix_t;

  typedef struct packed {
    logic [COLSUM_W-1:0] r;
    logic [COLSUM_W-1:0] g;
    logic [COLSUM_W-1:0] b;
  } colsum_t;

  typedef struct packed {
    logic valid;
    logic emit;
    logic row_end;
    logic frame_end;
  } flags_t;

  // ceil(2^24 / count) for every legal window pixel count
  function automatic logic [RECIP_W-1:0] recip(input logic [RAD_W-1:0] rx,
                                              input logic [RAD_W-1:0] ry);
    logic [5:0] cnt;
    logic [RECIP_W-1:0] m;
    cnt = 6'((2 * rx + 1) * (2 * ry + 1));
    case (cnt)
      6'd1:    m = 25'd16777216;
      6'd3:    m = 25'd5592406;
      6'd5:    m = 25'd3355444;
      6'd9:    m = 25'd1864136;
      6'd15:   m = 25'd1118482;
      6'd25:   m = 25'd671089;
      default: m = 25'd16777216;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/rgb_box_mean_filter.sv =====
// ---------------------------------------------------------------------------
// rgb_box_mean_filter
// Streaming RGB box blur over a (2*radius_x+1) by (2*radius_y+1) window.
// ---------------------------------------------------------------------------
// Pixels enter in raster order on in_valid/in_stall, one item per pixel.
// Each pixel whose window lies fully inside the frame yields one item on
// out_valid/out_stall carrying the truncated channel means, with
// out_row_end and out_frame_end marking the ends of the cropped rows/frame.
// Border pixels are consumed without a result.
// Throughput is one pixel per cycle while out_stall holds no waiting result;
// the line store is one 96-bit wide RAM read and written once per pixel, and
// a same-column forward covers a one-pixel-wide frame.
// The window is a row of column cells shifted once per pixel.
// When out_stall holds a waiting result, the whole pipeline freezes and
// in_stall is raised in the same cycle.
// Reset clears the counters and loads 1024 x 1024 with radius 2 by 2; the
// line store is not cleared. Writing frame_width or frame_height restarts
// the frame at the next pixel.
// ---------------------------------------------------------------------------
module rgb_box_mean_filter
  import rbmf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CH_W-1:0]   in_red,
  input  logic [CH_W-1:0]   in_green,
  input  logic [CH_W-1:0]   in_blue,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CH_W-1:0]   out_red,
  output logic [CH_W-1:0]   out_green,
  output logic [CH_W-1:0]   out_blue,
  output logic              out_row_end,
  output logic              out_frame_end
);

  logic [CFG_W-1:0]  width_r, height_r;
  logic [RAD_W-1:0]  rad_x_r, rad_y_r;
  logic [CFG_W-1:0]  w_eff, h_eff;
  logic [RAD_W-1:0]  rx, ry;
  logic [ADDR_W-1:0] x_r, x_nxt;
  logic [ROW_W-1:0]  y_r, y_nxt;
  logic              advance, accept;
  logic              last_col, last_row;

  flags_t            s0_flags, s1_flags_r, s2_flags_r, s3_flags_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [PIX_W-1:0]  s1_pix_r;
  logic [LINE_W-1:0] ram_q, line_col, line_wr;
  logic              fwd_hit_r;
  logic [LINE_W-1:0] fwd_data_r;
  colpix_t           col_new;
  colpix_t           cells [WIN_COLS+1];
  colsum_t           col_sum [WIN_COLS];
  logic [SUM_W-1:0]  sum_r, sum_g, sum_b;
  logic [SUM_W-1:0]  s3_r_r, s3_g_r, s3_b_r;
  logic [RECIP_W-1:0] s3_m_r;
  logic [SUM_W+RECIP_W-1:0] prod_r, prod_g, prod_b;
  logic              out_valid_r, out_row_end_r, out_frame_end_r;
  logic [CH_W-1:0]   out_red_r, out_green_r, out_blue_r;

  // effective configuration
  always_comb begin
    w_eff = (width_r == '0) ? CFG_W'(1) :
            (width_r > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : width_r;
    h_eff = (height_r == '0) ? CFG_W'(1) :
            (height_r > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : height_r;
    rx = (rad_x_r > RAD_W'(MAX_RADIUS_X)) ? RAD_W'(MAX_RADIUS_X) : rad_x_r;
    ry = (rad_y_r > RAD_W'(MAX_RADIUS_Y)) ? RAD_W'(MAX_RADIUS_Y) : rad_y_r;
  end

  assign advance  = !(out_valid_r && out_stall);
  assign in_stall = !advance;
  assign accept   = in_valid && advance;

  // position counters and result flags
  always_comb begin
    last_col = (CFG_W'(x_r) + CFG_W'(1)) == w_eff;
    last_row = (CFG_W'(y_r) + CFG_W'(1)) == h_eff;
    x_nxt = x_r + ADDR_W'(1);
    y_nxt = y_r;
    if (last_col) begin
      x_nxt = '0;
      y_nxt = last_row ? '0 : y_r + ROW_W'(1);
    end
    s0_flags.valid     = accept;
    s0_flags.emit      = (x_r >= ADDR_W'(2 * rx)) && (y_r >= ROW_W'(2 * ry));
    s0_flags.row_end   = last_col;
    s0_flags.frame_end = last_col && last_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(MAX_WIDTH);
      height_r <= CFG_W'(MAX_HEIGHT);
      rad_x_r  <= RAD_W'(MAX_RADIUS_X);
      rad_y_r  <= RAD_W'(MAX_RADIUS_Y);
      x_r      <= '0;
      y_r      <= '0;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FRAME_WIDTH: begin
          width_r <= cfg_data;
          x_r     <= '0;
          y_r     <= '0;
        end
        REG_FRAME_HEIGHT: begin
          height_r <= cfg_data;
          x_r      <= '0;
          y_r      <= '0;
        end
        REG_RADIUS_X: rad_x_r <= cfg_data[RAD_W-1:0];
        REG_RADIUS_Y: rad_y_r <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end else if (accept) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

  // line store: word at column x holds rows y-1 .. y-4
  rbmf_ram #(
    .WIDTH(LINE_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_flags_r.valid && advance),
    .wr_addr (s1_addr_r),
    .wr_data (line_wr),
    .rd_en   (accept),
    .rd_addr (x_r),
    .rd_data (ram_q)
  );

  assign line_col = fwd_hit_r ? fwd_data_r : ram_q;
  assign line_wr  = {line_col[LINE_W-PIX_W-1:0], s1_pix_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_flags_r <= '0;
      s2_flags_r <= '0;
      s3_flags_r <= '0;
      fwd_hit_r  <= 1'b0;
    end else if (advance) begin
      s1_flags_r <= s0_flags;
      s2_flags_r <= s1_flags_r;
      s3_flags_r <= s2_flags_r;
      fwd_hit_r  <= accept && s1_flags_r.valid && (s1_addr_r == x_r);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_addr_r  <= x_r;
      s1_pix_r   <= {in_blue, in_green, in_red};
      fwd_data_r <= line_wr;
    end
  end

  // new window column: current pixel on top of the stored rows
  assign col_new  = {line_col, s1_pix_r};
  assign cells[0] = col_new;

  for (genvar c = 0; c < WIN_COLS; c++) begin : g_cell
    rbmf_cell u_cell (
      .clk     (clk),
      .shift   (s1_flags_r.valid && advance),
      .ry      (ry),
      .col_in  (cells[c]),
      .col_out (cells[c+1]),
      .sum_out (col_sum[c])
    );
  end

  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int c = 0; c < WIN_COLS; c++) begin
      if (c <= 2 * rx) begin
        sum_r = sum_r + SUM_W'(col_sum[c].r);
        sum_g = sum_g + SUM_W'(col_sum[c].g);
        sum_b = sum_b + SUM_W'(col_sum[c].b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_r_r <= sum_r;
      s3_g_r <= sum_g;
      s3_b_r <= sum_b;
      s3_m_r <= recip(rx, ry);
    end
  end

  // division by the pixel count via reciprocal multiply
  assign prod_r = s3_r_r * s3_m_r;
  assign prod_g = s3_g_r * s3_m_r;
  assign prod_b = s3_b_r * s3_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s3_flags_r.valid && s3_flags_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_red_r       <= prod_r[RECIP_SH+CH_W-1:RECIP_SH];
      out_green_r     <= prod_g[RECIP_SH+CH_W-1:RECIP_SH];
      out_blue_r      <= prod_b[RECIP_SH+CH_W-1:RECIP_SH];
      out_row_end_r   <= s3_flags_r.row_end;
      out_frame_end_r <= s3_flags_r.frame_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = out_red_r;
  assign out_green     = out_green_r;
  assign out_blue      = out_blue_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

  a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_frame_end_r || out_row_end_r))
    else $error("frame end without row end");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    CFG_W'(x_r) < w_eff)
    else $error("column counter out of range");

  a_size_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr_en && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT))
    |=> (x_r == '0 && y_r == '0))
    else $error("frame size write did not restart the frame");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled without a waiting result");

endmodule

// ===== rtl/rbmf_ram.sv =====
// ---------------------------------------------------------------------------
// rbmf_ram
// Single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module rbmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/rbmf_cell.sv =====
// ---------------------------------------------------------------------------
// rbmf_cell
// One window column: holds its pixels, passes them to its neighbor and
// gives the column sums over the active rows.
// ---------------------------------------------------------------------------
module rbmf_cell
  import rbmf_pkg::*;
(
  input  logic             clk,
  input  logic             shift,
  input  logic [RAD_W-1:0] ry,
  input  colpix_t          col_in,
  output colpix_t          col_out,
  output colsum_t          sum_out
);

  colpix_t col_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      col_r <= col_in;
    end
  end

  always_comb begin
    sum_out = '0;
    for (int k = 0; k < WIN_ROWS; k++) begin
      if (k <= 2 * ry) begin
        sum_out.r = sum_out.r + COLSUM_W'(col_r[k][CH_W-1:0]);
        sum_out.g = sum_out.g + COLSUM_W'(col_r[k][2*CH_W-1:CH_W]);
        sum_out.b = sum_out.b + COLSUM_W'(col_r[k][3*CH_W-1:2*CH_W]);
      end
    end
  end

  assign col_out = col_r;

endmodule

// ===== bench/rbmf_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rbmf_checker
// Watches the channels of the box mean filter and checks every result.
// ---------------------------------------------------------------------------
// Tracks the register writes and every accepted pixel, works out the
// expected window mean for each pixel that completes a window, and compares
// each accepted result field by field with the oldest expected one.
// ---------------------------------------------------------------------------
module rbmf_checker
  import rbmf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [CH_W-1:0]  in_red,
  input  logic [CH_W-1:0]  in_green,
  input  logic [CH_W-1:0]  in_blue,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [CH_W-1:0]  out_red,
  input  logic [CH_W-1:0]  out_green,
  input  logic [CH_W-1:0]  out_blue,
  input  logic             out_row_end,
  input  logic             out_frame_end,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            row_end;
    logic            frame_end;
  } mean_t;

  mean_t            mean_q[$];
  logic [CFG_W-1:0] frame_w, frame_h;
  logic [RAD_W-1:0] rad_x, rad_y;
  int               col, row;
  logic [PIX_W-1:0] rows_seen[8][MAX_WIDTH];

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  task automatic take_pixel(input logic [CH_W-1:0] r, g, b);
    int    w, h, rx, ry, cnt, sr, sg, sb;
    mean_t m;
    w  = clamp(frame_w, 1, MAX_WIDTH);
    h  = clamp(frame_h, 1, MAX_HEIGHT);
    rx = clamp(rad_x, 0, MAX_RADIUS_X);
    ry = clamp(rad_y, 0, MAX_RADIUS_Y);
    rows_seen[row % 8][col] = {b, g, r};
    if (col >= 2 * rx && row >= 2 * ry && col < w && row < h) begin
      sr = 0; sg = 0; sb = 0;
      cnt = (2 * rx + 1) * (2 * ry + 1);
      for (int k = 0; k <= 2 * ry; k++)
        for (int c = 0; c <= 2 * rx; c++) begin
          sr += rows_seen[(row - k) % 8][col - c][7:0];
          sg += rows_seen[(row - k) % 8][col - c][15:8];
          sb += rows_seen[(row - k) % 8][col - c][23:16];
        end
      m.red       = CH_W'(sr / cnt);
      m.green     = CH_W'(sg / cnt);
      m.blue      = CH_W'(sb / cnt);
      m.row_end   = (col + 1 == w);
      m.frame_end = (col + 1 == w) && (row + 1 == h);
      mean_q.push_back(m);
    end
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
  endtask

  always @(posedge clk) begin
    mean_t e;
    if (!rst_n) begin
      frame_w <= 11'd1024; frame_h <= 11'd1024;
      rad_x <= 2'd2; rad_y <= 2'd2;
      col = 0; row = 0;
      fail_count = 0;
      mean_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (reg_idx_t'(cfg_index))
          REG_FRAME_WIDTH: begin
            frame_w <= cfg_data; col = 0; row = 0;
          end
          REG_FRAME_HEIGHT: begin
            frame_h <= cfg_data; col = 0; row = 0;
          end
          REG_RADIUS_X: rad_x <= cfg_data[RAD_W-1:0];
          REG_RADIUS_Y: rad_y <= cfg_data[RAD_W-1:0];
        endcase
      end
      if (in_valid && !in_stall) take_pixel(in_red, in_green, in_blue);
      if (out_valid && !out_stall) begin
        if (mean_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected: %0d %0d %0d %b %b", $time,
                   out_red, out_green, out_blue, out_row_end, out_frame_end);
        end else begin
          e = mean_q.pop_front();
          if (e != {out_red, out_green, out_blue, out_row_end, out_frame_end}) begin
            fail_count++;
            $display("%0t: mismatch exp r%0d g%0d b%0d re%b fe%b got r%0d g%0d b%0d re%b fe%b",
                     $time, e.red, e.green, e.blue, e.row_end, e.frame_end,
                     out_red, out_green, out_blue, out_row_end, out_frame_end);
          end
        end
      end
    end
    pending = mean_q.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the RGB box mean filter.
// ---------------------------------------------------------------------------
// Runs directed frames over the size and radius extremes, then random frame
// shapes with random pixels, with random idle bursts on both channels.
// ---------------------------------------------------------------------------
module testbench
  import rbmf_pkg::*;
();

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [CH_W-1:0]  in_red = '0, in_green = '0, in_blue = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [CH_W-1:0]  out_red, out_green, out_blue;
  logic             out_row_end, out_frame_end;
  int               fail_count, pending;
  int               quiet_cycles = 0;
  int               sent = 0;
  bit               idle_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rgb_box_mean_filter u_top (.*);

  rbmf_checker u_chk (.*);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 2000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_regs(input int w, h, rx, ry);
    int vals[4];
    vals = '{w, h, rx, ry};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data  <= CFG_W'(vals[i]);
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // caller is at a falling edge
  task automatic send_pixel(input logic [CH_W-1:0] r, g, b);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // mode 0: random, 1: all max, 2: all zero, 3: alternating extremes
  task automatic run_frames(input int w, h, rx, ry, frames, mode);
    int wc, hc, n;
    logic [CH_W-1:0] r, g, b;
    wc = (w < 1) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
    hc = (h < 1) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
    write_regs(w, h, rx, ry);
    n = wc * hc * frames;
    for (int i = 0; i < n; i++) begin
      case (mode)
        1: begin r = 8'hFF; g = 8'hFF; b = 8'hFF; end
        2: begin r = 8'h00; g = 8'h00; b = 8'h00; end
        3: begin
          r = i[0] ? 8'hFF : 8'h00; g = ~r; b = i[1] ? 8'hFF : 8'h00;
        end
        default: begin
          r = CH_W'($urandom); g = CH_W'($urandom); b = CH_W'($urandom);
        end
      endcase
      send_pixel(r, g, b);
    end
    drain();
  endtask

  initial begin
    int w, h;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_frames(3, 3, 1, 1, 1, 1);
    run_frames(3, 3, 1, 1, 1, 2);
    run_frames(5, 5, 2, 2, 1, 3);
    run_frames(2, 2, 1, 1, 1, 0);
    run_frames(0, 0, 0, 0, 2, 0);
    run_frames(4, 2, 3, 0, 1, 3);
    run_frames(2047, 1, 0, 0, 1, 0);

    while (sent < 1800) begin
      if (sent > 1500) idle_on = 1'b0;
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 12);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 10);
      run_frames(w, h, $urandom_range(0, 3), $urandom_range(0, 3),
                 $urandom_range(1, 3), ($urandom_range(0, 9) == 0) ? 3 : 0);
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rbmf_pkg.sv
rtl/rbmf_ram.sv
rtl/rbmf_cell.sv
rtl/rgb_box_mean_filter.sv
bench/rbmf_checker.sv
bench/testbench.sv
